FILE: hw/rtl/six_axis_moving_average_unit_defines.svh
// assertion macros for the six-axis moving average unit
`ifndef SIX_AXIS_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define SIX_AXIS_MOVING_AVERAGE_UNIT_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define SMAA_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("smaa check failed: same-cycle condition");

// condition must hold in the cycle after the trigger
`define SMAA_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("smaa check failed: next-cycle condition");

`endif

FILE: hw/rtl/smaa_pkg.sv
// shared constants, types and the reciprocal table of the moving average unit
`default_nettype none

package smaa_pkg;

   localparam int WINDOW_MAX   = 16;
   localparam int SAMPLE_BITS  = 16;
   localparam int AXES         = 6;
   localparam int SLOT_BITS    = $clog2(WINDOW_MAX);
   localparam int COUNT_BITS   = $clog2(WINDOW_MAX + 1);
   localparam int SUM_BITS     = SAMPLE_BITS + SLOT_BITS;
   localparam int RECIP_SHIFT  = 24;
   localparam int RECIP_BITS   = RECIP_SHIFT + 1;
   localparam int PROD_BITS    = SUM_BITS + RECIP_BITS;
   localparam int BEAT_BITS    = AXES * SAMPLE_BITS;

   localparam logic [COUNT_BITS-1:0] LEN_RESET = COUNT_BITS'(10);
   localparam logic [COUNT_BITS-1:0] LEN_MAX   = COUNT_BITS'(WINDOW_MAX);
   localparam logic [COUNT_BITS-1:0] LEN_MIN   = COUNT_BITS'(1);

   // ceil(2**24 / d) for d = 1 .. 16, exact floor for sums up to 2**20
   localparam logic [RECIP_BITS-1:0] RECIP_TABLE [0:WINDOW_MAX] = '{
      25'd0,
      25'd16777216, 25'd8388608,  25'd5592406,  25'd4194304,
      25'd3355444,  25'd2796203,  25'd2396746,  25'd2097152,
      25'd1864136,  25'd1677722,  25'd1525202,  25'd1398102,
      25'd1290556,  25'd1198373,  25'd1118482,  25'd1048576
   };

   // sequencer to lane control bundle
   typedef struct packed {
      logic                  accept;
      logic                  clear;
      logic                  full;
      logic [SLOT_BITS-1:0]  slot;
      logic                  acc_en;
      logic                  abs_en;
      logic                  mul_en;
      logic [RECIP_BITS-1:0] recip;
   } lane_ctl_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

endpackage

`default_nettype wire

FILE: hw/rtl/smaa_lane.sv
// one axis lane: sample history, running sum, magnitude and reciprocal divide
`default_nettype none

module smaa_lane (
   input  wire                      clock,
   input  wire                      reset,
   input  smaa_pkg::lane_ctl_type   ctl,
   input  smaa_pkg::sample_type     sample_in,
   output smaa_pkg::sample_type     mean_out
);
   import smaa_pkg::*;

   sample_type                   hist_mem [WINDOW_MAX];
   sample_type                   hist_rd_ff;
   sample_type                   sample_ff;
   logic signed [SUM_BITS-1:0]   sum_ff;
   logic signed [SUM_BITS-1:0]   sum_in;
   logic [SUM_BITS-1:0]          mag_ff;
   logic [SUM_BITS-1:0]          mag_in;
   logic                         neg_ff;
   logic [PROD_BITS-1:0]         prod;
   logic [SAMPLE_BITS-1:0]       quot_ff;

   // history ring: old entry read out as the new one goes in
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         hist_mem[ctl.slot] <= sample_in;
         hist_rd_ff         <= hist_mem[ctl.slot];
         sample_ff          <= sample_in;
      end
   end

   // running sum, oldest sample dropped once the window is full
   always_comb begin
      sum_in = sum_ff + SUM_BITS'(sample_ff);
      if (ctl.full) begin
         sum_in = sum_in - SUM_BITS'(hist_rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         sum_ff <= '0;
      end else if (ctl.acc_en) begin
         sum_ff <= sum_in;
      end
   end

   // sign and magnitude of the sum
   assign mag_in = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);

   always_ff @(posedge clock) begin
      if (ctl.abs_en) begin
         mag_ff <= mag_in;
         neg_ff <= sum_ff[SUM_BITS-1];
      end
   end

   // divide by the fill count through its reciprocal
   assign prod = {{RECIP_BITS{1'b0}}, mag_ff} * {{SUM_BITS{1'b0}}, ctl.recip};

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         quot_ff <= prod[RECIP_SHIFT +: SAMPLE_BITS];
      end
   end

   // restore the sign, truncation toward zero
   assign mean_out = neg_ff ? sample_type'(~quot_ff + 1'b1) : sample_type'(quot_ff);

endmodule

`default_nettype wire

FILE: hw/rtl/smaa_ctrl.sv
// sequencer: window length, fill count, ring slot and stage enables
`default_nettype none

module smaa_ctrl (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   accept,
   input  wire                                   csr_write,
   input  wire  [smaa_pkg::COUNT_BITS-1:0]       csr_len,
   input  wire                                   out_free,
   output logic                                  idle,
   output logic                                  load_out,
   output smaa_pkg::lane_ctl_type                ctl
);
   import smaa_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ACC  = 5'b00010,
      ST_ABS  = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type                state_ff;
   state_type                state_in;
   logic [COUNT_BITS-1:0]    len_ff;
   logic [COUNT_BITS-1:0]    len_in;
   logic [COUNT_BITS-1:0]    fill_ff;
   logic [SLOT_BITS-1:0]     slot_ff;
   logic                     full_ff;
   logic                     full_now;
   logic [COUNT_BITS-1:0]    slot_next;
   logic [RECIP_BITS-1:0]    recip_ff;

   // clamp the written window length to 1 .. WINDOW_MAX
   always_comb begin
      len_in = csr_len;
      if (csr_len == '0) begin
         len_in = LEN_MIN;
      end else if (csr_len > LEN_MAX) begin
         len_in = LEN_MAX;
      end
   end

   assign full_now  = (fill_ff == len_ff);
   assign slot_next = {1'b0, slot_ff} + COUNT_BITS'(1);

   // window length register
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
      end else if (csr_write) begin
         len_ff <= len_in;
      end
   end

   // fill count and ring slot, cleared by a length write
   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         fill_ff <= '0;
         slot_ff <= '0;
         full_ff <= 1'b0;
      end else if (accept) begin
         full_ff <= full_now;
         if (!full_now) begin
            fill_ff <= fill_ff + COUNT_BITS'(1);
         end
         if (slot_next >= len_ff) begin
            slot_ff <= '0;
         end else begin
            slot_ff <= slot_next[SLOT_BITS-1:0];
         end
      end
   end

   // reciprocal of the new fill count
   always_ff @(posedge clock) begin
      if (state_ff == ST_ACC) begin
         recip_ff <= RECIP_TABLE[fill_ff];
      end
   end

   // stage sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC:  state_in = ST_ABS;
         ST_ABS:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs
   assign idle       = (state_ff == ST_IDLE);
   assign load_out   = (state_ff == ST_DONE) && out_free;
   assign ctl.accept = accept;
   assign ctl.clear  = csr_write;
   assign ctl.full   = full_ff;
   assign ctl.slot   = slot_ff;
   assign ctl.acc_en = (state_ff == ST_ACC);
   assign ctl.abs_en = (state_ff == ST_ABS);
   assign ctl.mul_en = (state_ff == ST_MUL);
   assign ctl.recip  = recip_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/six_axis_moving_average_unit.sv
// six-axis boxcar moving average: top level with lanes and result register
// Each beat on req carries six signed 16-bit IMU axes and yields one beat on rsp holding,
// per axis, the mean of the last window_length samples (fewer while the window fills),
// truncated toward zero. Six lanes work side by side; an item passes these steps before the next
// one can be taken: history read with ring write, running-sum update, magnitude,
// reciprocal multiply, then sign restore into the result register once rsp is free.
// The result is held on rsp until taken and a new beat is accepted while it waits. A write
// on csr sets window_length (0 acts as 1, above 16 acts as 16) and clears the history;
// write it only while no item is in flight.
`default_nettype none

module six_axis_moving_average_unit (
   input  wire          clock,
   input  wire          reset,
   // req_tdata fields from bit 0: accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [95:0]  req_tdata,
   // rsp_tdata fields from bit 0: avg_accel_x, avg_accel_y, avg_accel_z,
   // avg_rate_x, avg_rate_y, avg_rate_z
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [95:0]  rsp_tdata,
   // window_length
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [4:0]   csr_data
);
   import smaa_pkg::*;
   `include "six_axis_moving_average_unit_defines.svh"

   logic                  req_fire;
   logic                  csr_fire;
   logic                  idle;
   logic                  load_out;
   logic                  out_free;
   lane_ctl_type          ctl;
   logic [BEAT_BITS-1:0]  means;
   logic [BEAT_BITS-1:0]  rsp_data_ff;
   logic                  rsp_valid_ff;

   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;
   assign csr_ready  = 1'b1;
   assign req_tready = idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   smaa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_fire),
      .csr_write (csr_fire),
      .csr_len   (csr_data),
      .out_free  (out_free),
      .idle      (idle),
      .load_out  (load_out),
      .ctl       (ctl)
   );

   // one lane per axis
   for (genvar a = 0; a < AXES; a++) begin : g_lane
      smaa_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .sample_in (sample_type'(req_tdata[a*SAMPLE_BITS +: SAMPLE_BITS])),
         .mean_out  (means[a*SAMPLE_BITS +: SAMPLE_BITS])
      );
   end

   // merge lane means into the result beat
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= means;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks on the sequencer and lane stages
   `SMAA_ASSERT_NEXT(a_accept_starts_sum, clock, reset, req_fire, ctl.acc_en && !req_tready)
   `SMAA_ASSERT_NEXT(a_sum_then_abs, clock, reset, ctl.acc_en, ctl.abs_en)
   `SMAA_ASSERT_SAME(a_one_stage, clock, reset, 1'b1, $onehot0({ctl.acc_en, ctl.abs_en, ctl.mul_en, load_out, req_tready}))

endmodule

`default_nettype wire

FILE: sim/six_axis_moving_average_unit_tb.sv
// self-checking testbench for the six-axis moving average unit
module six_axis_moving_average_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import smaa_pkg::*;

   localparam int QUIET_LIMIT   = 3000;
   localparam int LONG_STALL    = 300;
   localparam int SEGMENTS      = 18;
   localparam int SEGMENT_BEATS = 80;
   localparam int OPENING_BEATS = 12;

   // windowed mean predictor and store of expected result beats
   class imu_mean_board;
      logic [4:0]             window_reg;
      sample_type             ring [WINDOW_MAX][AXES];
      int                     axis_total [AXES];
      int                     stored;
      int                     next_slot;
      logic [BEAT_BITS-1:0]   pending_means [$];
      int                     failures;
      int                     checked;

      function new();
         failures = 0;
         checked  = 0;
         load_window(LEN_RESET);
      endfunction

      // any length write empties the ring and the running sums
      function void load_window(logic [4:0] value);
         window_reg = value;
         stored     = 0;
         next_slot  = 0;
         for (int a = 0; a < AXES; a++) begin
            axis_total[a] = 0;
            for (int s = 0; s < WINDOW_MAX; s++) begin
               ring[s][a] = '0;
            end
         end
      endfunction

      function void note_sample(logic [BEAT_BITS-1:0] beat);
         int                   span;
         int                   slot;
         bit                   full;
         sample_type           s;
         logic [BEAT_BITS-1:0] means;
         // zero acts as one, anything above the ring depth saturates
         span = (window_reg == 0) ? 1 : (window_reg > WINDOW_MAX) ? WINDOW_MAX : window_reg;
         slot = (next_slot >= span) ? 0 : next_slot;
         if (stored > span) begin
            stored = span;
         end
         full = (stored == span);
         for (int a = 0; a < AXES; a++) begin
            s = beat[a*SAMPLE_BITS +: SAMPLE_BITS];
            if (full) begin
               axis_total[a] -= ring[slot][a];
            end
            ring[slot][a] = s;
            axis_total[a] += s;
         end
         if (!full) begin
            stored++;
         end
         next_slot = (slot + 1 >= span) ? 0 : slot + 1;
         // signed int division truncates toward zero
         for (int a = 0; a < AXES; a++) begin
            means[a*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(axis_total[a] / stored);
         end
         pending_means.insert(pending_means.size(), means);
      endfunction

      function void check_means(logic [BEAT_BITS-1:0] beat);
         logic [BEAT_BITS-1:0] want;
         sample_type           want_v;
         sample_type           got_v;
         string                lane_names [AXES] = '{"avg_accel_x", "avg_accel_y",
            "avg_accel_z", "avg_rate_x", "avg_rate_y", "avg_rate_z"};
         if (pending_means.size() == 0) begin
            $error("result beat %h with no sample waiting", beat);
            failures++;
            return;
         end
         want = pending_means[0];
         pending_means.delete(0);
         checked++;
         for (int a = 0; a < AXES; a++) begin
            want_v = want[a*SAMPLE_BITS +: SAMPLE_BITS];
            got_v  = beat[a*SAMPLE_BITS +: SAMPLE_BITS];
            if (got_v !== want_v) begin
               $error("%s: expected %0d, actual %0d", lane_names[a], want_v, got_v);
               failures++;
            end
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [95:0]          req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [95:0]          rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [4:0]           csr_data   = '0;

   imu_mean_board        board = new();
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;
   int                   stall_asked   = 0;
   int                   stall_given   = 0;
   int                   stall_left    = 0;
   int                   samples_sent  = 0;
   int                   windows_used  = 1;

   // lengths per segment, extremes and out-of-range codes included
   logic [4:0] window_plan [SEGMENTS] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2,
      5'd5, 5'd10, 5'd3, 5'd7, 5'd16, 5'd4, 5'd12, 5'd0, 5'd9, 5'd15, 5'd6, 5'd31};

   // axis order: accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
   sample_type opening [OPENING_BEATS][AXES] = '{
      '{-3, 5, 32767, -32768, 0, -1},
      '{0, 0, 32767, -32768, -1, -1},
      '{32767, -32768, -32768, 32767, 1, -1},
      '{-32768, 32767, -32768, 32767, -2, 2},
      '{21845, -21846, 21845, -21846, 21845, -21846},
      '{-21846, 21845, -21846, 21845, -21846, 21845},
      '{-1, -1, -1, -1, -1, -1},
      '{32767, 32767, 32767, 32767, 32767, 32767},
      '{-32768, -32768, -32768, -32768, -32768, -32768},
      '{0, 0, 0, 0, 0, 0},
      '{100, -100, 7, -7, 1, -1},
      '{-32768, 32767, -32768, 32767, -32768, 32767}
   };

   six_axis_moving_average_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 50 MHz clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // predictor follows every accepted beat and length write
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            board.note_sample(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            board.check_means(rsp_tdata);
         end
         if (csr_valid && csr_ready) begin
            board.load_window(csr_data);
         end
      end
   end

   // receiver back-pressure, with one long hold-off on request
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_asked != stall_given) begin
         rsp_tready  <= 1'b0;
         stall_left  <= LONG_STALL;
         stall_given <= stall_given + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles without any accepted beat
   initial begin
      int quiet;
      quiet = 0;
      wait (reset == 1'b0);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("six_axis_moving_average_unit: mismatch");
      $finish;
   end

   // biased towards the range ends and around zero
   function automatic sample_type pick_axis_value();
      case ($urandom_range(9))
         0:       return sample_type'(16'h8000);
         1:       return sample_type'(16'h7fff);
         2:       return '0;
         3:       return '1;
         4:       return sample_type'($urandom_range(16)) - sample_type'(8);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // offer one beat after a random gap and hold it until taken
   task automatic send_sample(logic [BEAT_BITS-1:0] beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      do @(posedge clock); while (!req_tready);
      samples_sent++;
   endtask

   // stop offering and wait until every expected mean has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending_means.size() != 0);
   endtask

   task automatic write_window(logic [4:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic send_opening(int first, int last);
      logic [BEAT_BITS-1:0] beat;
      for (int i = first; i <= last; i++) begin
         for (int a = 0; a < AXES; a++) begin
            beat[a*SAMPLE_BITS +: SAMPLE_BITS] = opening[i][a];
         end
         send_sample(beat);
      end
   endtask

   // single samples mixed with runs of 2 to 20 held values
   task automatic play_segment(int count);
      int                   left;
      int                   run;
      sample_type           held [AXES];
      logic [BEAT_BITS-1:0] beat;
      left = count;
      while (left > 0) begin
         run = ($urandom_range(3) == 0) ? $urandom_range(2, 20) : 1;
         for (int a = 0; a < AXES; a++) begin
            held[a] = pick_axis_value();
         end
         while (run > 0 && left > 0) begin
            for (int a = 0; a < AXES; a++) begin
               beat[a*SAMPLE_BITS +: SAMPLE_BITS] = held[a];
            end
            send_sample(beat);
            run--;
            left--;
         end
      end
   endtask

   // stimulus and end of run
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset length, then one and zero, with partial and full windows
      send_idle_pct = 17;
      recv_idle_pct = 61;
      send_opening(0, OPENING_BEATS - 1);
      write_window(5'd1);
      send_opening(0, 2);
      write_window(5'd0);
      send_opening(3, 4);
      windows_used += 2;

      // random segments over three idling regimes
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < SEGMENTS / 3) begin
            send_idle_pct = 17;
            recv_idle_pct = 61;
         end else if (seg < 2 * SEGMENTS / 3) begin
            send_idle_pct = 61;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_window(window_plan[seg]);
         windows_used++;
         if (seg == 2 * SEGMENTS / 3 + 1) begin
            stall_asked++;
         end
         play_segment(SEGMENT_BEATS);
      end

      drain();
      repeat (12) @(posedge clock);

      $display("covered %0d samples, %0d mean beats checked, %0d window settings",
               samples_sent, board.checked, windows_used);
      $display("with zero and saturated lengths, partial windows and a long output hold-off");
      if (board.failures == 0 && board.pending_means.size() == 0) begin
         $display("six_axis_moving_average_unit: match");
      end else begin
         $display("six_axis_moving_average_unit: mismatch");
      end
      $finish;
   end

endmodule
